### design/sss_pkg.sv
// Package of the stack selection sorter: shared constants, state and control types.
package sss_pkg;

    localparam int unsigned STACK_DEPTH_DEF = 32;
    localparam int unsigned VALUE_W         = 32;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_PASS_RD,
        ST_SCAN,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_POP_RD,
        ST_POP_LD,
        ST_POP_WAIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic pass_init;
        logic scan;
        logic swap_a;
        logic swap_b;
        logic pop_rd;
        logic pop_ld;
        logic pop_next;
        logic run_done;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_end;
        logic pass_last;
        logic pop_last;
    } status_t;

endpackage

### design/sss_if.sv
// Stream interfaces of the stack selection sorter: input beats and result beats.
interface sss_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [sss_pkg::VALUE_W-1:0] value;
    logic                               last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface sss_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [sss_pkg::VALUE_W-1:0] value_res;
    logic                               last_res;
    logic                               overflow;

    modport source (output valid, output value_res, output last_res, output overflow,
                    input ready);
    modport sink   (input valid, input value_res, input last_res, input overflow,
                    output ready);
endinterface

### design/sss_ctrl.sv
// Controller state machine of the stack selection sorter.
module sss_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  sss_pkg::status_t status,
    output sss_pkg::cmd_t    cmd
);

    sss_pkg::state_t state_reg;
    sss_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sss_pkg::ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            sss_pkg::ST_COLLECT:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        state_next = sss_pkg::ST_PASS_RD;
                    end
                end
            end
            sss_pkg::ST_PASS_RD:
            begin
                cmd.pass_init = 1'b1;
                state_next    = sss_pkg::ST_SCAN;
            end
            sss_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_end)
                begin
                    state_next = sss_pkg::ST_SWAP_A;
                end
            end
            sss_pkg::ST_SWAP_A:
            begin
                cmd.swap_a = 1'b1;
                state_next = sss_pkg::ST_SWAP_B;
            end
            sss_pkg::ST_SWAP_B:
            begin
                cmd.swap_b = 1'b1;
                state_next = status.pass_last ? sss_pkg::ST_POP_RD : sss_pkg::ST_PASS_RD;
            end
            sss_pkg::ST_POP_RD:
            begin
                cmd.pop_rd = 1'b1;
                state_next = sss_pkg::ST_POP_LD;
            end
            sss_pkg::ST_POP_LD:
            begin
                cmd.pop_ld = 1'b1;
                state_next = sss_pkg::ST_POP_WAIT;
            end
            sss_pkg::ST_POP_WAIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.pop_last)
                    begin
                        cmd.run_done = 1'b1;
                        state_next   = sss_pkg::ST_COLLECT;
                    end
                    else
                    begin
                        cmd.pop_next = 1'b1;
                        state_next   = sss_pkg::ST_POP_RD;
                    end
                end
            end
            default:
            begin
                state_next = sss_pkg::ST_COLLECT;
            end
        endcase
    end

endmodule

### design/sss_datapath.sv
// Datapath of the stack selection sorter: stack memory, scan registers and result register.
module sss_datapath
#(
    parameter int unsigned STACK_DEPTH = sss_pkg::STACK_DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  sss_pkg::cmd_t                      cmd,
    output sss_pkg::status_t                   status,
    input  logic signed [sss_pkg::VALUE_W-1:0] in_value,
    output logic signed [sss_pkg::VALUE_W-1:0] value_res,
    output logic                               last_res,
    output logic                               overflow
);

    localparam int unsigned IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    logic signed [sss_pkg::VALUE_W-1:0] mem [STACK_DEPTH];
    logic signed [sss_pkg::VALUE_W-1:0] rd_data_reg;

    logic [CW-1:0] cnt_reg;
    logic          dropped_reg;
    logic [IW-1:0] p_reg;
    logic [IW-1:0] q_reg;
    logic [IW-1:0] best_idx_reg;
    logic signed [sss_pkg::VALUE_W-1:0] best_val_reg;
    logic signed [sss_pkg::VALUE_W-1:0] pval_reg;
    logic signed [sss_pkg::VALUE_W-1:0] value_res_reg;
    logic          last_res_reg;
    logic          overflow_reg;

    logic [CW-1:0] cnt_m1;
    logic [IW-1:0] last_idx;
    logic [IW-1:0] q_inc;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic signed [sss_pkg::VALUE_W-1:0] wr_data;
    logic          room;

    assign cnt_m1   = cnt_reg - CW'(1);
    assign last_idx = cnt_m1[IW-1:0];
    assign q_inc    = q_reg + IW'(1);
    assign room     = (cnt_reg < CW'(STACK_DEPTH));

    assign status.scan_end  = (q_reg == last_idx);
    assign status.pass_last = (p_reg == last_idx);
    assign status.pop_last  = (p_reg == '0);

    // Read address and write port selection.
    always_comb
    begin
        rd_addr = p_reg;
        if (cmd.scan)
        begin
            rd_addr = q_inc;
        end

        wr_en   = 1'b0;
        wr_addr = cnt_reg[IW-1:0];
        wr_data = in_value;
        if (cmd.load && room)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.swap_a)
        begin
            wr_en   = 1'b1;
            wr_addr = best_idx_reg;
            wr_data = pval_reg;
        end
        else if (cmd.swap_b)
        begin
            wr_en   = 1'b1;
            wr_addr = p_reg;
            wr_data = best_val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            dropped_reg <= 1'b0;
            p_reg       <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (room)
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                else
                begin
                    dropped_reg <= 1'b1;
                end
            end
            if (cmd.swap_b && !status.pass_last)
            begin
                p_reg <= p_reg + IW'(1);
            end
            if (cmd.pop_next)
            begin
                p_reg <= p_reg - IW'(1);
            end
            if (cmd.run_done)
            begin
                cnt_reg     <= '0;
                dropped_reg <= 1'b0;
                p_reg       <= '0;
            end
        end
    end

    // Scan and result registers carry payload only.
    always_ff @(posedge clk)
    begin
        if (cmd.pass_init)
        begin
            q_reg <= p_reg;
        end
        if (cmd.scan)
        begin
            q_reg <= q_inc;
            if (q_reg == p_reg)
            begin
                pval_reg     <= rd_data_reg;
                best_val_reg <= rd_data_reg;
                best_idx_reg <= q_reg;
            end
            else if (rd_data_reg > best_val_reg)
            begin
                best_val_reg <= rd_data_reg;
                best_idx_reg <= q_reg;
            end
        end
        if (cmd.pop_ld)
        begin
            value_res_reg <= rd_data_reg;
            last_res_reg  <= (p_reg == '0);
            overflow_reg  <= dropped_reg;
        end
    end

    assign value_res = value_res_reg;
    assign last_res  = last_res_reg;
    assign overflow  = overflow_reg;

endmodule

### design/stack_selection_sorter.sv
// Top level of the stack selection sorter: controller and datapath joined to the stream ports.
//
// Values arrive one beat per cycle and are pushed onto a stack memory of STACK_DEPTH
// entries; a push into a full stack is dropped and flags overflow on every result of that
// run. The beat marked last is pushed too and starts an in-place selection sort: each pass
// scans the unsorted top part of the stack through the single registered read port of the
// memory, one entry per cycle, keeps the running maximum, and then swaps it down onto the
// sorted part with two writes. The stack is then popped, smallest value first, one result
// beat at a time: each beat is read, loaded into the result register and held until the
// sink is ready; last_res marks the final beat, after which the stack is empty and the
// input accepts a new set. Input beats are taken only while collecting. The memory needs
// no clearing after reset: only entries that were written in the current set are ever
// used. The default depth is 32 entries.
module stack_selection_sorter
#(
    parameter int unsigned STACK_DEPTH = sss_pkg::STACK_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    sss_in_if.sink    in_ch,
    sss_out_if.source out_ch
);

    sss_pkg::cmd_t    cmd;
    sss_pkg::status_t status;

    // The controller owns both handshakes; the datapath holds the data.
    sss_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_last   (in_ch.last),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    sss_datapath
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_value  (in_ch.value),
        .value_res (out_ch.value_res),
        .last_res  (out_ch.last_res),
        .overflow  (out_ch.overflow)
    );

endmodule
